>>> rtl/core/assert_macros.svh
// Assertion macros shared by the lookup core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is high.
`define OHSL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define OHSL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OHSL_ASSERT(label, clk, rst, prop, msg)
`define OHSL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/ohsl_pkg.sv
// Types, constants and helper functions for the opcode hash set lookup core.
package ohsl_pkg;

   localparam int SLOTS_PER_BUCKET = 16;
   localparam int BUCKET_COUNT     = 7;
   localparam int KEY_W            = 40;
   localparam int KEY_BYTES        = KEY_W / 8;
   localparam int ENTRY_DEPTH      = BUCKET_COUNT * SLOTS_PER_BUCKET;
   localparam int ADDR_W           = $clog2(ENTRY_DEPTH);
   localparam int COUNT_W          = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int BKT_W            = $clog2(BUCKET_COUNT);

   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_J = 8'h6a;
   localparam logic [7:0] CH_L = 8'h6c;
   localparam logic [7:0] CH_N = 8'h6e;
   localparam logic [7:0] CH_O = 8'h6f;
   localparam logic [7:0] CH_S = 8'h73;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NO_BUCKET = 2'd2;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic             hit;
      logic [BKT_W-1:0] idx;
   } bkt_sel_type;

   // Zero every byte from the first zero byte downward.
   function automatic logic [KEY_W-1:0] text_of(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] txt;
      logic             live;
      txt  = '0;
      live = 1'b1;
      for (int b = KEY_BYTES - 1; b >= 0; b--) begin
         if (key[8*b +: 8] == 8'h00) live = 1'b0;
         if (live) txt[8*b +: 8] = key[8*b +: 8];
      end
      return txt;
   endfunction

   function automatic bkt_sel_type bucket_of(input logic [7:0] ch);
      bkt_sel_type sel;
      sel.hit = 1'b1;
      case (ch)
         CH_A:    sel.idx = BKT_W'(0);
         CH_B:    sel.idx = BKT_W'(1);
         CH_J:    sel.idx = BKT_W'(2);
         CH_L:    sel.idx = BKT_W'(3);
         CH_N:    sel.idx = BKT_W'(4);
         CH_O:    sel.idx = BKT_W'(5);
         CH_S:    sel.idx = BKT_W'(6);
         default: begin
            sel.hit = 1'b0;
            sel.idx = '0;
         end
      endcase
      return sel;
   endfunction

endpackage

>>> rtl/core/ohsl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ohsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/opcode_hash_set_lookup_core.sv
// Opcode hash set: bucketed key store with insert and membership search.
// Insert or unbucketed key: result decided in S_EVAL, then registered to the output or parked in S_DONE.
// Search: one entry RAM read per cycle over the bucket's stored keys, stopping early
// on a match; no new item is accepted until the result is in the output register.
// Reset clears the bucket counts and control; the entry RAM is not cleared (no sweep).
`include "assert_macros.svh"
module opcode_hash_set_lookup_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ohsl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ohsl_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_DONE} state_type;

   state_type                      state_ff, state_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ohsl_pkg::rsp_type              rsp_ff, rsp_in;
   ohsl_pkg::rsp_type              res_ff, res_in;
   logic [ohsl_pkg::COUNT_W-1:0]   count_ff [ohsl_pkg::BUCKET_COUNT];
   logic [ohsl_pkg::COUNT_W-1:0]   count_in [ohsl_pkg::BUCKET_COUNT];
   logic [ohsl_pkg::KEY_W-1:0]     key_ff, key_in;
   logic                           kind_ff, kind_in;
   logic                           hit_ff, hit_in;
   logic [ohsl_pkg::BKT_W-1:0]     bkt_ff, bkt_in;
   logic [ohsl_pkg::COUNT_W-1:0]   slot_ff, slot_in;

   ohsl_pkg::bkt_sel_type          sel;
   logic [ohsl_pkg::COUNT_W-1:0]   cnt;
   logic [ohsl_pkg::COUNT_W-1:0]   slot_sel;
   logic [ohsl_pkg::COUNT_W-1:0]   slot_nxt;
   logic [ohsl_pkg::ADDR_W-1:0]    base;
   logic                           rsp_free;
   logic                           fin;
   ohsl_pkg::rsp_type              fin_val;

   logic                           ram_wr_en;
   logic [ohsl_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [ohsl_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [ohsl_pkg::KEY_W-1:0]     ram_rd_data;

   ohsl_ram #(
      .WIDTH(ohsl_pkg::KEY_W),
      .DEPTH(ohsl_pkg::ENTRY_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (key_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign sel         = ohsl_pkg::bucket_of(req_data.key[ohsl_pkg::KEY_W-1 -: 8]);
   assign cnt         = count_ff[bkt_ff];
   assign slot_nxt    = slot_ff + ohsl_pkg::COUNT_W'(1);
   assign base        = ohsl_pkg::ADDR_W'(bkt_ff) *
                        ohsl_pkg::ADDR_W'(ohsl_pkg::SLOTS_PER_BUCKET);
   assign ram_wr_addr = base + ohsl_pkg::ADDR_W'(cnt);
   assign ram_rd_addr = base + ohsl_pkg::ADDR_W'(slot_sel);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      kind_in      = kind_ff;
      hit_in       = hit_ff;
      bkt_in       = bkt_ff;
      slot_in      = slot_ff;
      slot_sel     = '0;
      ram_wr_en    = 1'b0;
      fin          = 1'b0;
      fin_val      = '{found: 1'b0, status: ohsl_pkg::ST_OK};

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = ohsl_pkg::text_of(req_data.key);
               kind_in  = req_data.kind;
               hit_in   = sel.hit;
               bkt_in   = sel.idx;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!hit_ff) begin
               fin            = 1'b1;
               fin_val.status = ohsl_pkg::ST_NO_BUCKET;
            end else if (kind_ff == ohsl_pkg::KIND_INSERT) begin
               fin = 1'b1;
               if (cnt >= ohsl_pkg::COUNT_W'(ohsl_pkg::SLOTS_PER_BUCKET)) begin
                  fin_val.status = ohsl_pkg::ST_FULL;
               end else begin
                  ram_wr_en        = 1'b1;
                  count_in[bkt_ff] = cnt + ohsl_pkg::COUNT_W'(1);
               end
            end else if (cnt == '0) begin
               fin = 1'b1;
            end else begin
               // read slot 0 now, data arrives in the first scan cycle
               slot_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ram_rd_data == key_ff) begin
               fin           = 1'b1;
               fin_val.found = 1'b1;
            end else if (slot_nxt == cnt) begin
               fin = 1'b1;
            end else begin
               slot_sel = slot_nxt;
               slot_in  = slot_nxt;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // park the result when the output register is still held
      if (fin) begin
         if (rsp_free) begin
            rsp_in       = fin_val;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            res_in   = fin_val;
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_ff  <= rsp_in;
      res_ff  <= res_in;
      key_ff  <= key_in;
      kind_ff <= kind_in;
      hit_ff  <= hit_in;
      bkt_ff  <= bkt_in;
      slot_ff <= slot_in;
   end

   `OHSL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "reset did not idle the core")
   `OHSL_ASSERT(a_accept_eval, clock, reset, (req_valid && !req_stall) |=> state_ff == S_EVAL, "accepted item did not enter evaluation")
   `OHSL_ASSERT(a_write_room, clock, reset, ram_wr_en |-> (state_ff == S_EVAL && cnt < ohsl_pkg::COUNT_W'(ohsl_pkg::SLOTS_PER_BUCKET)), "entry write into a full bucket")
   `OHSL_ASSERT(a_count_inc, clock, reset, ram_wr_en |=> count_ff[$past(bkt_ff)] == $past(cnt) + ohsl_pkg::COUNT_W'(1), "bucket count not advanced on insert")
   `OHSL_ASSERT(a_scan_range, clock, reset, state_ff == S_SCAN |-> (hit_ff && kind_ff == ohsl_pkg::KIND_SEARCH && slot_ff < cnt), "scan outside stored slots")

endmodule
